### hdl/dns_query_packet_builder_top_defines.svh
// Assertion macros shared by the DNS query builder checkers.
// No dependencies; taken in by `include.
`ifndef DNS_QUERY_PACKET_BUILDER_TOP_DEFINES_SVH
`define DNS_QUERY_PACKET_BUILDER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DNSQB_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DNSQB_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/dnsqb_pkg.sv
// Package for the DNS query packet builder: codes, widths, cell control
// struct and byte-table functions. No dependencies.
`default_nettype none

package dnsqb_pkg;

  localparam logic [1:0] ACT_BEGIN = 2'd0;
  localparam logic [1:0] ACT_CHAR  = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_EMPTY   = 2'd1;
  localparam logic [1:0] ERR_LONG    = 2'd2;
  localparam logic [1:0] ERR_OUTSIDE = 2'd3;

  localparam logic [1:0] CFG_FLAGS = 2'd0;
  localparam logic [1:0] CFG_TYPE  = 2'd1;
  localparam logic [1:0] CFG_CLASS = 2'd2;

  localparam logic [7:0] DOT_CHAR = 8'h2E;

  localparam logic [1:0] BC_NONE = 2'd0;
  localparam logic [1:0] BC_ONE  = 2'd1;
  localparam logic [1:0] BC_TWO  = 2'd2;

  localparam int LEN_W = 6;   // label length, up to 63
  localparam int IDX_W = 7;   // cell index / byte count, up to 69

  localparam logic [IDX_W-1:0] HDR_BYTES  = 7'd12;
  localparam logic [IDX_W-1:0] TAIL_BYTES = 7'd5;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_OPEN = 3'b010,
    PH_DROP = 3'b100
  } phase_t;

  typedef struct packed {
    logic             drain;    // shift chain down by two bytes
    logic             ld_hdr;   // load header into cells 0..11
    logic             ld_char;  // store char at cell len+1
    logic             ld_len;   // store length byte in cell 0
    logic             ld_tail;  // store terminator, type, class after label
    logic [LEN_W-1:0] len;
    logic [7:0]       ch;
    logic [15:0]      qid;
    logic [15:0]      flags;
    logic [15:0]      qtype;
    logic [15:0]      qclass;
  } cell_ctrl_t;

  function automatic logic [7:0] header_byte(input logic [3:0] idx,
                                             input logic [15:0] qid,
                                             input logic [15:0] flags);
    logic [7:0] b;
    case (idx)
      4'd0:    b = qid[15:8];
      4'd1:    b = qid[7:0];
      4'd2:    b = flags[15:8];
      4'd3:    b = flags[7:0];
      4'd5:    b = 8'd1;       // question count low byte
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] tail_byte(input logic [2:0] idx,
                                           input logic [15:0] qtype,
                                           input logic [15:0] qclass);
    logic [7:0] b;
    case (idx)
      3'd1:    b = qtype[15:8];
      3'd2:    b = qtype[7:0];
      3'd3:    b = qclass[15:8];
      3'd4:    b = qclass[7:0];
      default: b = 8'd0;       // root terminator
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### hdl/dnsqb_in_if.sv
// Request channel interface of the DNS query builder.
// Stand-alone; no package needed.
`default_nettype none

interface dnsqb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] query_id;
  logic [7:0]  name_char;

  modport source(output valid, action, query_id, name_char, input ready);
  modport sink(input valid, action, query_id, name_char, output ready);
endinterface

`default_nettype wire

### hdl/dnsqb_out_if.sv
// Result word channel interface of the DNS query builder.
// Stand-alone; no package needed.
`default_nettype none

interface dnsqb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] word_high;
  logic [7:0] word_low;
  logic [1:0] byte_count;
  logic       last_of_run;
  logic       end_of_packet;
  logic [1:0] error_code;

  modport source(output valid, word_high, word_low, byte_count, last_of_run,
                 end_of_packet, error_code, input ready);
  modport sink(input valid, word_high, word_low, byte_count, last_of_run,
               end_of_packet, error_code, output ready);
endinterface

`default_nettype wire

### hdl/dnsqb_cell.sv
// One byte cell of the packet chain: loads by its own index, shifts by two.
// Depends on dnsqb_pkg.
`default_nettype none

module dnsqb_cell #(
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  dnsqb_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]            from_next,
  output logic [7:0]            data
);

  localparam int W = dnsqb_pkg::IDX_W;

  logic [W-1:0] my_idx;
  logic [W-1:0] len_ext;
  logic [W-1:0] tail_off;
  logic [7:0]   data_next;

  assign my_idx   = W'(IDX);
  assign len_ext  = W'(ctrl.len);
  assign tail_off = my_idx - len_ext - W'(1);

  always_comb begin
    data_next = data;
    if (ctrl.drain) begin
      data_next = from_next;
    end else if (ctrl.ld_hdr) begin
      if (my_idx < dnsqb_pkg::HDR_BYTES) begin
        data_next = dnsqb_pkg::header_byte(my_idx[3:0], ctrl.qid, ctrl.flags);
      end
    end else begin
      if (ctrl.ld_char && my_idx == len_ext + W'(1)) begin
        data_next = ctrl.ch;
      end
      if (ctrl.ld_len && my_idx == '0) begin
        data_next = 8'(ctrl.len);
      end
      if (ctrl.ld_tail && my_idx > len_ext && tail_off < dnsqb_pkg::TAIL_BYTES) begin
        data_next = dnsqb_pkg::tail_byte(tail_off[2:0], ctrl.qtype, ctrl.qclass);
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

### hdl/dns_query_packet_builder_top.sv
// DNS query packet builder top level: control, byte-cell chain, output reg.
// Depends on dnsqb_pkg, dnsqb_in_if, dnsqb_out_if, dnsqb_cell.
//
//  channel   dir   handshake          payload
//  item      in    valid/ready        action, query_id, name_char
//  word      out   valid/ready        word_high, word_low, byte_count,
//                                     last_of_run, end_of_packet, error_code
//  cfg       in    cfg_we (no ready)  cfg_index, cfg_data
//
// A character request adds to the label. A begin, a dot or an end request loads
// the cell chain, which then drains out of cells 0 and 1, one word per cycle
// while the output is not stalled. Synchronous active-high reset clears phase,
// label length, drain count and the output valid; cell contents are not reset.
// A stalled output holds its word and the chain waits; no request is taken while
// the chain drains.
`default_nettype none

module dns_query_packet_builder_top #(
  parameter int MAX_LABEL_LEN = 63
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  dnsqb_in_if.sink           item,
  dnsqb_out_if.source        word
);

  localparam int LW = dnsqb_pkg::LEN_W;
  localparam int CW = dnsqb_pkg::IDX_W;
  // Cell 0 holds the length byte, label bytes follow, then five tail bytes.
  // At least twelve cells so the header fits.
  localparam int NCELL = (MAX_LABEL_LEN + 6 > 12) ? MAX_LABEL_LEN + 6 : 12;

  // Config registers
  logic [15:0] header_flags, query_type, query_class;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_flags <= 16'h0100;
      query_type   <= 16'd1;
      query_class  <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        dnsqb_pkg::CFG_FLAGS: header_flags <= cfg_data;
        dnsqb_pkg::CFG_TYPE:  query_type   <= cfg_data;
        dnsqb_pkg::CFG_CLASS: query_class  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control state
  dnsqb_pkg::phase_t phase, phase_next;
  logic [LW-1:0]     label_length, label_length_next;
  logic [CW-1:0]     cnt, cnt_next;    // bytes left in the chain
  logic              eop, eop_next;    // chain holds the packet's last word

  // Output register
  logic       out_valid;
  logic [7:0] out_high, out_low;
  logic [1:0] out_bc, out_err;
  logic       out_last, out_eop;

  logic       out_free, accept, drain;
  logic       err_ld;
  logic [1:0] err_code;

  dnsqb_pkg::cell_ctrl_t ctrl;
  logic [7:0] cell_q [NCELL];

  assign out_free   = !out_valid || word.ready;
  assign item.ready = (cnt == '0) && out_free;
  assign accept     = item.valid && item.ready;
  assign drain      = (cnt != '0) && out_free;

  // Request decode
  always_comb begin
    phase_next        = phase;
    label_length_next = label_length;
    cnt_next          = cnt;
    eop_next          = eop;
    err_ld            = 1'b0;
    err_code          = dnsqb_pkg::ERR_NONE;

    ctrl         = '0;
    ctrl.drain   = drain;
    ctrl.len     = label_length;
    ctrl.ch      = item.name_char;
    ctrl.qid     = item.query_id;
    ctrl.flags   = header_flags;
    ctrl.qtype   = query_type;
    ctrl.qclass  = query_class;

    if (drain) begin
      cnt_next = (cnt >= CW'(2)) ? cnt - CW'(2) : '0;
    end

    if (accept) begin
      case (item.action)
        dnsqb_pkg::ACT_BEGIN: begin
          ctrl.ld_hdr       = 1'b1;
          cnt_next          = dnsqb_pkg::HDR_BYTES;
          eop_next          = 1'b0;
          phase_next        = dnsqb_pkg::PH_OPEN;
          label_length_next = '0;
        end
        dnsqb_pkg::ACT_CHAR, dnsqb_pkg::ACT_END: begin
          if (phase == dnsqb_pkg::PH_IDLE) begin
            err_ld   = 1'b1;
            err_code = dnsqb_pkg::ERR_OUTSIDE;
          end else if (phase == dnsqb_pkg::PH_OPEN) begin
            if (item.action == dnsqb_pkg::ACT_CHAR &&
                item.name_char != dnsqb_pkg::DOT_CHAR) begin
              if (label_length >= LW'(MAX_LABEL_LEN)) begin
                err_ld            = 1'b1;
                err_code          = dnsqb_pkg::ERR_LONG;
                phase_next        = dnsqb_pkg::PH_DROP;
                label_length_next = '0;
              end else begin
                ctrl.ld_char      = 1'b1;
                label_length_next = label_length + LW'(1);
              end
            end else if (label_length == '0) begin
              err_ld     = 1'b1;
              err_code   = dnsqb_pkg::ERR_EMPTY;
              phase_next = dnsqb_pkg::PH_DROP;
            end else begin
              // label flush: length byte goes in cell 0
              ctrl.ld_len       = 1'b1;
              label_length_next = '0;
              cnt_next          = CW'(label_length) + CW'(1);
              eop_next          = 1'b0;
              if (item.action == dnsqb_pkg::ACT_END) begin
                ctrl.ld_tail = 1'b1;
                cnt_next     = CW'(label_length) + dnsqb_pkg::TAIL_BYTES + CW'(1);
                eop_next     = 1'b1;
                phase_next   = dnsqb_pkg::PH_IDLE;
              end
            end
          end
          // dropped query: no result, no change
        end
        default: ;  // unused action, ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= dnsqb_pkg::PH_IDLE;
      label_length <= '0;
      cnt          <= '0;
      eop          <= 1'b0;
    end else begin
      phase        <= phase_next;
      label_length <= label_length_next;
      cnt          <= cnt_next;
      eop          <= eop_next;
    end
  end

  // Byte-cell chain; each cell takes the byte two places up on a drain.
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    logic [7:0] nxt;
    if (g + 2 < NCELL) begin : g_mid
      assign nxt = cell_q[g+2];
    end else begin : g_end
      assign nxt = 8'd0;
    end
    dnsqb_cell #(.IDX(g)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .from_next (nxt),
      .data      (cell_q[g])
    );
  end

  // Output register: error results load directly, words come from the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (err_ld || drain) begin
      out_valid <= 1'b1;
    end else if (word.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (err_ld) begin
      out_high <= 8'd0;
      out_low  <= 8'd0;
      out_bc   <= dnsqb_pkg::BC_NONE;
      out_last <= 1'b1;
      out_eop  <= 1'b0;
      out_err  <= err_code;
    end else if (drain) begin
      out_high <= cell_q[0];
      out_low  <= (cnt >= CW'(2)) ? cell_q[1] : 8'd0;
      out_bc   <= (cnt >= CW'(2)) ? dnsqb_pkg::BC_TWO : dnsqb_pkg::BC_ONE;
      out_last <= (cnt <= CW'(2));
      out_eop  <= (cnt <= CW'(2)) && eop;
      out_err  <= dnsqb_pkg::ERR_NONE;
    end
  end

  assign word.valid         = out_valid;
  assign word.word_high     = out_high;
  assign word.word_low      = out_low;
  assign word.byte_count    = out_bc;
  assign word.last_of_run   = out_last;
  assign word.end_of_packet = out_eop;
  assign word.error_code    = out_err;

endmodule

`default_nettype wire

### hdl/dnsqb_checker.sv
// Port-level checker for the DNS query builder, bound to the top level.
// Depends on dnsqb_pkg and dns_query_packet_builder_top_defines.svh.
`default_nettype none
`include "dns_query_packet_builder_top_defines.svh"

module dnsqb_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_high,
  input wire logic [7:0] out_low,
  input wire logic [1:0] out_bc,
  input wire logic       out_last,
  input wire logic       out_eop,
  input wire logic [1:0] out_err
);

  `DNSQB_ASSERT_NOW(a_err_shape, clk, rst, out_valid && out_err != dnsqb_pkg::ERR_NONE, out_bc == dnsqb_pkg::BC_NONE && out_last && !out_eop, "error result not a lone empty word")
  `DNSQB_ASSERT_NOW(a_eop_last, clk, rst, out_valid && out_eop, out_last && out_bc != dnsqb_pkg::BC_NONE && out_err == dnsqb_pkg::ERR_NONE, "end of packet off a run's last data word")
  `DNSQB_ASSERT_NOW(a_odd_tail, clk, rst, out_valid && out_bc == dnsqb_pkg::BC_ONE, out_low == 8'd0 && out_last, "single-byte word not last or low byte set")
  `DNSQB_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_high) && $stable(out_low) && $stable(out_bc) && $stable(out_err), "stalled word changed")

endmodule

bind dns_query_packet_builder_top dnsqb_checker u_dnsqb_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (word.valid),
  .out_ready (word.ready),
  .out_high  (word.word_high),
  .out_low   (word.word_low),
  .out_bc    (word.byte_count),
  .out_last  (word.last_of_run),
  .out_eop   (word.end_of_packet),
  .out_err   (word.error_code)
);

`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for dns_query_packet_builder_top: drives begin, name
// and end requests, predicts every packet word and compares on the fly.
// Depends on dns_query_packet_builder_top, dnsqb_pkg, dnsqb_in_if and dnsqb_out_if from the hdl folder.
`timescale 1ns / 100ps

module tb_top;

  localparam int MAX_LABEL       = 63;
  localparam int DRAIN_WAIT      = 80;    // end request drains up to 35 words
  localparam int STALL_LIMIT     = 4000;  // cycles with no handshake at all
  localparam int HOLDOFF_CYCLES  = 400;
  localparam int RANDOM_REQUESTS = 20;

  // Codes the package leaves unnamed: spare action and spare register index.
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [7:0] hi;
    logic [7:0] lo;
    logic [1:0] nbytes;
    logic       last;
    logic       eop;
    logic [1:0] err;
  } qword_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  dnsqb_in_if  item_ch();
  dnsqb_out_if word_ch();

  dns_query_packet_builder_top #(
    .MAX_LABEL_LEN(MAX_LABEL)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .item     (item_ch),
    .word     (word_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Packet predictor: its own copy of the registers and the label state.
  // ---------------------------------------------------------------------
  logic [15:0]       flags_reg = 16'h0100;
  logic [15:0]       type_reg  = 16'h0001;
  logic [15:0]       class_reg = 16'h0001;
  dnsqb_pkg::phase_t query_phase = dnsqb_pkg::PH_IDLE;
  int                label_len = 0;
  logic [7:0]        label_buf [MAX_LABEL];
  logic [7:0]        packet_bytes [$];    // bytes of one request, before packing
  qword_t            packet_words [$];    // words still owed by the block

  int  err_count = 0;
  int  words_seen = 0;
  int  requests_sent = 0;           // requests that were not simply ignored
  int  queries_done = 0;
  bit  steady = 1'b0;               // no idling on either side
  int  holdoff_req = 0;             // bump to start one receiver hold-off

  function automatic void stage_word(input logic [15:0] w);
    packet_bytes.push_back(w[15:8]);
    packet_bytes.push_back(w[7:0]);
  endfunction

  // Pack staged bytes high byte first; a request's output starts on a fresh word.
  function automatic void pack_bytes(input bit eop);
    int     n;
    int     k;
    qword_t w;
    n = packet_bytes.size();
    for (k = 0; k < n; k += 2) begin
      w.hi     = packet_bytes[k];
      w.lo     = (k + 1 < n) ? packet_bytes[k + 1] : 8'h00;
      w.nbytes = (k + 1 < n) ? dnsqb_pkg::BC_TWO : dnsqb_pkg::BC_ONE;
      w.last   = (k + 2 >= n);
      w.eop    = w.last && eop;
      w.err    = dnsqb_pkg::ERR_NONE;
      packet_words.push_back(w);
    end
    packet_bytes.delete();
  endfunction

  function automatic void push_error(input logic [1:0] code);
    qword_t w;
    w        = '0;
    w.nbytes = dnsqb_pkg::BC_NONE;
    w.last   = 1'b1;
    w.err    = code;
    packet_words.push_back(w);
  endfunction

  // Returns 1 unless the block ignores the request outright.
  function automatic bit predict_request(input logic [1:0] act,
                                         input logic [15:0] qid,
                                         input logic [7:0] ch);
    int k;
    if (act == dnsqb_pkg::ACT_BEGIN) begin
      stage_word(qid);
      stage_word(flags_reg);
      stage_word(16'd1);
      for (k = 0; k < 3; k++) stage_word(16'd0);
      query_phase = dnsqb_pkg::PH_OPEN;
      label_len   = 0;
      pack_bytes(1'b0);
      return 1'b1;
    end
    if (act == ACT_SPARE) return 1'b0;
    if (query_phase == dnsqb_pkg::PH_IDLE) begin
      push_error(dnsqb_pkg::ERR_OUTSIDE);
      return 1'b1;
    end
    if (query_phase == dnsqb_pkg::PH_DROP) return 1'b0;
    if (act == dnsqb_pkg::ACT_CHAR && ch != dnsqb_pkg::DOT_CHAR) begin
      if (label_len >= MAX_LABEL) begin
        query_phase = dnsqb_pkg::PH_DROP;
        label_len   = 0;
        push_error(dnsqb_pkg::ERR_LONG);
        return 1'b1;
      end
      label_buf[label_len] = ch;
      label_len++;
      return 1'b1;
    end
    // dot or end closes the current label
    if (label_len == 0) begin
      query_phase = dnsqb_pkg::PH_DROP;
      push_error(dnsqb_pkg::ERR_EMPTY);
      return 1'b1;
    end
    packet_bytes.push_back(8'(label_len));
    for (k = 0; k < label_len; k++) packet_bytes.push_back(label_buf[k]);
    label_len = 0;
    if (act == dnsqb_pkg::ACT_CHAR) begin
      pack_bytes(1'b0);
      return 1'b1;
    end
    packet_bytes.push_back(8'h00);
    stage_word(type_reg);
    stage_word(class_reg);
    query_phase = dnsqb_pkg::PH_IDLE;
    queries_done++;
    pack_bytes(1'b1);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Request driver: random gaps, valid stays up across back-to-back requests.
  // ---------------------------------------------------------------------
  task automatic send_request(input logic [1:0] act, input logic [15:0] qid,
                             input logic [7:0] ch);
    if (!steady)
      while ($urandom_range(99) < 31) begin
        item_ch.valid <= 1'b0;
        @(posedge clk);
      end
    item_ch.valid     <= 1'b1;
    item_ch.action    <= act;
    item_ch.query_id  <= qid;
    item_ch.name_char <= ch;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    if (predict_request(act, qid, ch)) requests_sent++;
  endtask

  task automatic send_begin(input logic [15:0] qid);
    send_request(dnsqb_pkg::ACT_BEGIN, qid, 8'($urandom));
  endtask

  task automatic send_char(input logic [7:0] ch);
    send_request(dnsqb_pkg::ACT_CHAR, 16'($urandom), ch);
  endtask

  task automatic send_end();
    send_request(dnsqb_pkg::ACT_END, 16'($urandom), 8'($urandom));
  endtask

  // Label of random non-dot bytes, zero byte and 0xFF included.
  task automatic send_label(input int len);
    logic [7:0] ch;
    int         i;
    for (i = 0; i < len; i++) begin
      ch = 8'($urandom_range(254));
      if (ch >= dnsqb_pkg::DOT_CHAR) ch = ch + 8'd1;
      send_char(ch);
    end
  endtask

  // Mostly well-formed query with short labels; some labels empty, and now
  // and then the end is left off so the next begin abandons it.
  task automatic send_random_query();
    int n_labels;
    int len;
    int j;
    int r;
    send_begin(16'($urandom));
    n_labels = $urandom_range(1, 4);
    for (j = 0; j < n_labels; j++) begin
      r = $urandom_range(99);
      if (r < 6) len = 0;
      else       len = $urandom_range(1, 6);
      send_label(len);
      if (j < n_labels - 1)             send_char(dnsqb_pkg::DOT_CHAR);
      else if ($urandom_range(99) >= 8) send_end();
    end
  endtask

  task automatic send_noise();
    send_request(2'($urandom_range(3)), 16'($urandom), 8'($urandom));
  endtask

  // ---------------------------------------------------------------------
  // Register writes: only once every owed word is out and the chain is quiet.
  // ---------------------------------------------------------------------
  task automatic settle();
    item_ch.valid <= 1'b0;
    while (packet_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Leaves cfg_we high so writes can run back to back; caller drops it.
  task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      dnsqb_pkg::CFG_FLAGS: flags_reg = val;
      dnsqb_pkg::CFG_TYPE:  type_reg  = val;
      dnsqb_pkg::CFG_CLASS: class_reg = val;
      default: ;  // spare index, no effect
    endcase
  endtask

  task automatic load_config(input logic [15:0] flags, input logic [15:0] qtype,
                             input logic [15:0] qclass);
    settle();
    write_register(dnsqb_pkg::CFG_FLAGS, flags);
    write_register(dnsqb_pkg::CFG_TYPE, qtype);
    write_register(dnsqb_pkg::CFG_CLASS, qclass);
    write_register(CFG_SPARE, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset register values, requests outside a query, ignored action,
  // dropped queries, abandon by begin and extreme ids and bytes.
  task automatic test_reset_defaults();
    send_char(8'h61);                 // name byte with no query open
    send_end();                       // end with no query open
    send_request(ACT_SPARE, 16'hFFFF, 8'hFF);
    send_begin(16'h0000);
    send_char(8'h00);                 // zero is a plain name byte
    send_char(8'hFF);
    send_char(dnsqb_pkg::DOT_CHAR);
    send_request(ACT_SPARE, 16'h0000, 8'h00);
    send_char(8'h7A);
    send_end();
    send_begin(16'hFFFF);
    send_char(dnsqb_pkg::DOT_CHAR);   // empty first label drops the query
    send_char(8'h62);                 // silent while dropped
    send_end();
    send_begin(16'h1234);             // begin recovers from a dropped query
    send_char(8'h77);
    send_char(dnsqb_pkg::DOT_CHAR);
    send_end();                       // empty final label
    send_begin(16'hA5A5);
    send_char(8'h71);
    send_begin(16'h5A5A);             // abandons the open query
    send_char(8'h6D);
    send_end();
  endtask

  task automatic test_config_extremes();
    load_config(16'h0000, 16'h0000, 16'h0000);
    send_begin(16'($urandom));
    send_label(3);
    send_char(dnsqb_pkg::DOT_CHAR);
    send_label(1);
    send_end();
    load_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_begin(16'($urandom));
    send_label(2);
    send_end();
  endtask

  // Full-length label: biggest end packet, then one byte past the limit.
  task automatic test_long_labels();
    send_begin(16'($urandom));
    send_label(MAX_LABEL);
    send_end();
    send_begin(16'($urandom));
    send_label(MAX_LABEL + 1);
  endtask

  task automatic test_random_traffic();
    int start;
    start = requests_sent;
    while (requests_sent - start < RANDOM_REQUESTS) begin
      if ($urandom_range(99) < 15) send_noise();
      else                         send_random_query();
      if ($urandom_range(99) < 12)
        load_config(16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    repeat (2) send_random_query();
    steady = 1'b0;
  endtask

  // Receiver stops taking words while requests keep coming, so the chain
  // backs up and the request side has to stall.
  task automatic test_output_holdoff();
    steady = 1'b1;
    holdoff_req++;
    send_begin(16'($urandom));
    send_label(5);
    send_char(dnsqb_pkg::DOT_CHAR);
    send_label(3);
    send_end();
    send_begin(16'($urandom));
    send_label(2);
    send_end();
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Result sink: random stalls, no-stall stretch, one long hold-off.
  // ---------------------------------------------------------------------
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    word_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_req != hold_seen) begin
        hold_seen = holdoff_req;
        hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        word_ch.ready <= 1'b0;
      end else if (steady) begin
        word_ch.ready <= 1'b1;
      end else begin
        word_ch.ready <= ($urandom_range(99) >= 31);
      end
    end
  end

  // Every accepted word is checked against the oldest owed word.
  always @(posedge clk) begin
    qword_t got;
    qword_t want;
    if (!rst && word_ch.valid && word_ch.ready) begin
      got = '{word_ch.word_high, word_ch.word_low, word_ch.byte_count,
              word_ch.last_of_run, word_ch.end_of_packet, word_ch.error_code};
      words_seen++;
      if (packet_words.size() == 0) begin
        err_count++;
        $display("%0t: unexpected word hi=%h lo=%h n=%0d last=%b eop=%b err=%0d",
                 $time, got.hi, got.lo, got.nbytes, got.last, got.eop, got.err);
      end else begin
        want = packet_words.pop_front();
        if (got !== want) begin
          err_count++;
          $display("%0t: word mismatch expected hi=%h lo=%h n=%0d last=%b eop=%b err=%0d,",
                   $time, want.hi, want.lo, want.nbytes, want.last, want.eop,
                   want.err);
          $display("    actual hi=%h lo=%h n=%0d last=%b eop=%b err=%0d",
                   got.hi, got.lo, got.nbytes, got.last, got.eop, got.err);
        end
      end
    end
  end

  // Watchdog: too long with no handshake on either channel ends the run.
  int quiet = 0;
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (word_ch.valid && word_ch.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d words still owed",
               $time, STALL_LIMIT, packet_words.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= dnsqb_pkg::CFG_FLAGS;
    cfg_data          <= 16'h0000;
    item_ch.valid     <= 1'b0;
    item_ch.action    <= dnsqb_pkg::ACT_BEGIN;
    item_ch.query_id  <= 16'h0000;
    item_ch.name_char <= 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_config_extremes();
    test_long_labels();
    test_random_traffic();
    test_back_to_back();
    test_output_holdoff();

    // drain whatever is owed, then give stray words a chance to show up
    settle();

    $display("Run covered %0d live requests, %0d words, %0d complete queries.",
             requests_sent, words_seen, queries_done);
    $display("Label limits, register extremes, hold-off and back-to-back traffic included.");
    if (err_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/dnsqb_pkg.sv
hdl/dnsqb_in_if.sv
hdl/dnsqb_out_if.sv
hdl/dnsqb_cell.sv
hdl/dns_query_packet_builder_top.sv
hdl/dnsqb_checker.sv
bench/tb_top.sv
